@@ src/rft_pkg.sv @@
// ----------------------------------------------------------------------------
// rft_pkg
// Shared types and constants for the ring finger table.
// ----------------------------------------------------------------------------
package rft_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int QDEPTH  = 2;
  localparam int QIDX_W  = 1;
  localparam int QCNT_W  = 2;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_RANGE  = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_ADD,
    OP_RANGE,
    OP_LOOKUP
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t         op;
    logic        wrap;
    logic [31:0] key;
    logic [31:0] new_value;
    logic [31:0] range_low;
    logic [31:0] range_high;
  } cmd_t;

endpackage

@@ src/rft_req_if.sv @@
// ----------------------------------------------------------------------------
// rft_req_if
// Request channel: one operation per beat.
// ----------------------------------------------------------------------------
interface rft_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] key;
  logic [31:0] new_value;
  logic [31:0] range_low;
  logic [31:0] range_high;

  modport source (output valid, kind, key, new_value, range_low, range_high, input ready);
  modport sink   (input valid, kind, key, new_value, range_low, range_high, output ready);
endinterface

@@ src/rft_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rft_rsp_if
// Response channel: one result per beat.
// ----------------------------------------------------------------------------
interface rft_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_value;

  modport source (output valid, status, found_value, input ready);
  modport sink   (input valid, status, found_value, output ready);
endinterface

@@ src/rft_queue.sv @@
// ----------------------------------------------------------------------------
// rft_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module rft_queue
  import rft_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t              slots [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr;
  logic [QIDX_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/rft_front.sv @@
// ----------------------------------------------------------------------------
// rft_front
// Accepts request beats and decodes them into back-end commands.
// ----------------------------------------------------------------------------
module rft_front
  import rft_pkg::*;
(
  rft_req_if.sink req,
  input  logic    q_full,
  output logic    push,
  output cmd_t    push_data
);

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  always_comb begin
    push_data.key        = req.key;
    push_data.new_value  = req.new_value;
    push_data.range_low  = req.range_low;
    push_data.range_high = req.range_high;
    push_data.wrap       = (req.range_high < req.range_low);
    case (kind_t'(req.kind))
      KIND_ADD:    push_data.op = OP_ADD;
      // equal bounds select nothing
      KIND_RANGE:  push_data.op = (req.range_high == req.range_low) ? OP_NOP : OP_RANGE;
      KIND_LOOKUP: push_data.op = OP_LOOKUP;
      default:     push_data.op = OP_NOP;
    endcase
  end

endmodule

@@ src/rft_back.sv @@
// ----------------------------------------------------------------------------
// rft_back
// Slot table and scan sequencer; one slot per cycle, result register out.
// ----------------------------------------------------------------------------
module rft_back
  import rft_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  rft_rsp_if.source rsp
);

  logic [31:0]      keys   [ENTRIES];
  logic [31:0]      values [ENTRIES];
  logic [ENTRIES-1:0] vld;

  state_t           state;
  state_t           state_next;
  cmd_t             cur;
  logic [IDX_W-1:0] idx;
  logic             any;
  logic             dup;
  logic             have_free;
  logic [IDX_W-1:0] free_idx;
  logic             have_floor;
  logic [31:0]      min_key;
  logic [31:0]      min_val;
  logic [31:0]      floor_key;
  logic [31:0]      floor_val;
  logic             res_valid;
  logic [1:0]       res_status;
  logic [31:0]      res_value;

  logic             load;
  logic             last;
  logic [31:0]      rd_key;
  logic [31:0]      rd_val;
  logic             rd_vld;
  logic             hit;
  logic [1:0]       status_next;
  logic [31:0]      value_next;

  assign rd_key = keys[idx];
  assign rd_val = values[idx];
  assign rd_vld = vld[idx];
  assign last   = (idx == IDX_W'(ENTRIES - 1));
  assign hit    = cur.wrap ? ((rd_key > cur.range_low) || (rd_key <= cur.range_high))
                           : ((rd_key > cur.range_low) && (rd_key <= cur.range_high));

  assign rsp.valid       = res_valid;
  assign rsp.status      = res_status;
  assign rsp.found_value = res_value;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.op == OP_NOP) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = (state == S_IDLE) && cmd_valid;
    load    = (state == S_DONE) && (!res_valid || rsp.ready);
  end

  always_comb begin
    status_next = STAT_OK;
    value_next  = '0;
    case (cur.op)
      OP_ADD: begin
        if (dup) begin
          status_next = STAT_DUP;
        end else if (!have_free) begin
          status_next = STAT_FULL;
        end
      end
      OP_LOOKUP: begin
        if (!any) begin
          status_next = STAT_EMPTY;
        end else begin
          value_next = have_floor ? floor_val : min_val;
        end
      end
      default: begin
        status_next = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      vld       <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
      if (load && cur.op == OP_ADD && !dup && have_free) begin
        vld[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && cur.op == OP_RANGE && rd_vld && hit) begin
      values[idx] <= cur.new_value;
    end
    if (load && cur.op == OP_ADD && !dup && have_free) begin
      keys[free_idx]   <= cur.key;
      values[free_idx] <= cur.new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_status <= status_next;
      res_value  <= value_next;
    end
    case (state)
      S_IDLE: begin
        cur        <= cmd;
        idx        <= '0;
        any        <= 1'b0;
        dup        <= 1'b0;
        have_free  <= 1'b0;
        have_floor <= 1'b0;
      end
      S_SCAN: begin
        idx <= idx + 1'b1;
        if (rd_vld) begin
          any <= 1'b1;
          if (rd_key == cur.key) begin
            dup <= 1'b1;
          end
          if (!any || rd_key < min_key) begin
            min_key <= rd_key;
            min_val <= rd_val;
          end
          if (rd_key <= cur.key && (!have_floor || rd_key > floor_key)) begin
            floor_key  <= rd_key;
            floor_val  <= rd_val;
            have_floor <= 1'b1;
          end
        end else if (!have_free) begin
          have_free <= 1'b1;
          free_idx  <= idx;
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

endmodule

@@ src/ring_finger_table_top.sv @@
// ----------------------------------------------------------------------------
// ring_finger_table_top
// Key/value table on a 32-bit ring: add, ring range update, floor lookup.
// ----------------------------------------------------------------------------
// Each request beat returns exactly one response beat, in order. Add,
// range update and lookup walk all ENTRIES slots through the table's single
// read port, one slot per cycle; an unused kind or a range with equal bounds
// skips the scan. A two-deep command queue lets requests be taken while the
// back end scans, and a response register holds a result while the next
// operation proceeds up to its finish.
module ring_finger_table_top
  import rft_pkg::*;
(
  input logic       clk,
  input logic       rst,
  rft_req_if.sink   req,
  rft_rsp_if.source rsp
);

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_data;
  cmd_t pop_data;

  rft_front u_front (
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  rft_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  rft_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd       (pop_data),
    .cmd_pop   (pop),
    .rsp       (rsp)
  );

endmodule

@@ verif/rft_checker.sv @@
// ----------------------------------------------------------------------------
// rft_checker
// Watches the request and response channels of the ring finger table. It
// keeps its own copy of the table, works out the status and value that every
// accepted request beat must return, and compares each response beat, field
// by field, with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module rft_checker
  import rft_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rft_req_if   req,
  rft_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    status_t     status;
    logic [31:0] found;
  } table_result_t;

  logic [31:0]   slot_key  [ENTRIES];
  logic [31:0]   slot_val  [ENTRIES];
  logic          slot_used [ENTRIES];
  table_result_t result_q  [$];
  table_result_t oldest;

  function automatic table_result_t predict_op(kind_t kind, logic [31:0] key,
                                               logic [31:0] nv, logic [31:0] lo,
                                               logic [31:0] hi);
    table_result_t r;
    int            free_slot;
    bit            dup;
    bit            any;
    bit            have_floor;
    logic [31:0]   min_key;
    logic [31:0]   min_val;
    logic [31:0]   floor_key;
    logic [31:0]   floor_val;
    r.status   = STAT_OK;
    r.found    = '0;
    free_slot  = -1;
    dup        = 1'b0;
    any        = 1'b0;
    have_floor = 1'b0;
    min_key    = '0;
    min_val    = '0;
    floor_key  = '0;
    floor_val  = '0;
    case (kind)
      KIND_ADD: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i]) begin
            if (slot_key[i] == key) dup = 1'b1;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (dup) begin
          r.status = STAT_DUP;
        end else if (free_slot < 0) begin
          r.status = STAT_FULL;
        end else begin
          slot_key[free_slot]  = key;
          slot_val[free_slot]  = nv;
          slot_used[free_slot] = 1'b1;
        end
      end
      KIND_RANGE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i] &&
              (((hi > lo) && (slot_key[i] > lo) && (slot_key[i] <= hi)) ||
               ((hi < lo) && ((slot_key[i] > lo) || (slot_key[i] <= hi)))))
            slot_val[i] = nv;
        end
      end
      KIND_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i]) begin
            if (!any || slot_key[i] < min_key) begin
              min_key = slot_key[i];
              min_val = slot_val[i];
            end
            any = 1'b1;
            if (slot_key[i] <= key && (!have_floor || slot_key[i] > floor_key)) begin
              floor_key  = slot_key[i];
              floor_val  = slot_val[i];
              have_floor = 1'b1;
            end
          end
        end
        if (!any) r.status = STAT_EMPTY;
        else r.found = have_floor ? floor_val : min_val;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      result_q.delete();
      fail_count = 0;
    end else begin
      // response first: a request taken at this edge cannot answer at it
      if (rsp.valid && rsp.ready) begin
        if (result_q.size() == 0) begin
          $error("response beat with nothing outstanding: status %0d, found_value %h",
                 rsp.status, rsp.found_value);
          fail_count++;
        end else begin
          oldest = result_q.pop_front();
          if (rsp.status !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, rsp.status);
            fail_count++;
          end
          if (rsp.found_value !== oldest.found) begin
            $error("found_value: expected %h, actual %h", oldest.found, rsp.found_value);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready)
        result_q.insert(result_q.size(),
                        predict_op(kind_t'(req.kind), req.key, req.new_value,
                                   req.range_low, req.range_high));
    end
    pending = result_q.size();
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Top of the ring finger table bench. Drives a directed set of adds, range
// updates and lookups covering the ring edge cases, then random operations
// biased toward keys already in the table, under bursty request traffic and
// patterned response stalls. Checking is done by rft_checker.
// ----------------------------------------------------------------------------
module tb;
  import rft_pkg::*;

  localparam int RANDOM_OPS = 1530;

  logic        clk;
  logic        rst;
  int          fail_count;
  int          pending;
  int          burst_left;
  bit          long_stall_go;
  bit          long_stall_done;
  logic [31:0] key_pool [$];

  rft_req_if req_ch ();
  rft_rsp_if rsp_ch ();

  ring_finger_table_top DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  rft_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // one request beat; when a burst runs out, it is usually preceded by an idle gap
  task automatic offer(kind_t kind, logic [31:0] key, logic [31:0] nv,
                       logic [31:0] lo, logic [31:0] hi);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= kind;
    req_ch.key        <= key;
    req_ch.new_value  <= nv;
    req_ch.range_low  <= lo;
    req_ch.range_high <= hi;
    do @(posedge clk); while (!req_ch.ready);
    if (kind == KIND_ADD && key_pool.size() < 64) key_pool.insert(key_pool.size(), key);
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    int          r;
    logic [31:0] k;
    r = $urandom_range(0, 9);
    if (key_pool.size() != 0 && r < 4) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else if (key_pool.size() != 0 && r == 4) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      k = $urandom_range(0, 1) ? k + 32'd1 : k - 32'd1;
    end else if (r == 5) begin
      case ($urandom_range(0, 3))
        0:       k = 32'h0000_0000;
        1:       k = 32'hffff_ffff;
        2:       k = 32'h8000_0000;
        default: k = 32'h7fff_ffff;
      endcase
    end else begin
      k = $urandom;
    end
    return k;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // response stalls: always ready, coin flip, mostly stalled stretches, one long stall
  initial begin : receiver
    int mode;
    int mode_left;
    int held;
    mode      = 0;
    mode_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_go && !long_stall_done) begin
        rsp_ch.ready <= 1'b0;
        held = 0;
        while (held < 300) begin
          @(negedge clk);
          held++;
        end
        long_stall_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
          default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int          r;
    logic [31:0] lo;
    logic [31:0] hi;
    burst_left        = 0;
    long_stall_go     = 1'b0;
    long_stall_done   = 1'b0;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.kind       = KIND_ADD;
    req_ch.key        = '0;
    req_ch.new_value  = '0;
    req_ch.range_low  = '0;
    req_ch.range_high = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    offer(KIND_LOOKUP, 32'h0000_0000, 32'h0, 32'h0, 32'h0);            // empty table
    offer(KIND_RANGE,  32'h0, 32'h1111_1111, 32'h5, 32'ha);            // range on empty
    offer(KIND_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    offer(KIND_ADD,    32'd100, 32'hffff_ffff, 32'h0, 32'h0);
    offer(KIND_LOOKUP, 32'd50, 32'h0, 32'h0, 32'h0);                   // below every key
    offer(KIND_LOOKUP, 32'd100, 32'h0, 32'h0, 32'h0);
    offer(KIND_ADD,    32'hffff_ffff, 32'h0000_0000, 32'h0, 32'h0);
    offer(KIND_ADD,    32'd100, 32'h0bad_0bad, 32'h0, 32'h0);           // duplicate
    offer(KIND_ADD,    32'h8000_0000, 32'h5a5a_5a5a, 32'h0, 32'h0);
    offer(KIND_LOOKUP, 32'hffff_ffff, 32'h0, 32'h0, 32'h0);
    offer(KIND_LOOKUP, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0);
    offer(KIND_RANGE,  32'h0, 32'h0000_0001, 32'd100, 32'd100);         // equal bounds
    offer(KIND_LOOKUP, 32'd100, 32'h0, 32'h0, 32'h0);
    offer(KIND_RANGE,  32'h0, 32'h1234_5678, 32'h8000_0000, 32'd100);   // wrapping
    offer(KIND_LOOKUP, 32'hffff_ffff, 32'h0, 32'h0, 32'h0);
    offer(KIND_LOOKUP, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    offer(KIND_RANGE,  32'h0, 32'hdead_beef, 32'd99, 32'd100);
    offer(KIND_LOOKUP, 32'd150, 32'h0, 32'h0, 32'h0);
    offer(KIND_RANGE,  32'h0, 32'hcafe_f00d, 32'h0, 32'hffff_ffff);
    offer(KIND_ADD,    32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0);
    offer(KIND_RANGE,  32'h0, 32'h0f0f_0f0f, 32'hffff_ffff, 32'h0);     // wraps onto key 0
    offer(KIND_LOOKUP, 32'd99, 32'h0, 32'h0, 32'h0);
    offer(KIND_LOOKUP, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0);
    drain();

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == 200) long_stall_go = 1'b1;
      if (n == RANDOM_OPS / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 20) begin
        offer(KIND_ADD, pick_key(), pick_value(), $urandom, $urandom);
      end else if (r < 50) begin
        lo = pick_key();
        hi = ($urandom_range(0, 15) == 0) ? lo : pick_key();
        offer(KIND_RANGE, $urandom, pick_value(), lo, hi);
      end else if (r < 95) begin
        offer(KIND_LOOKUP, pick_key(), $urandom, $urandom, $urandom);
      end else begin
        offer(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
